// ===== src/wfs_pkg.sv =====
// Shared types, codes and constants for the windowed FIR smoother
`timescale 1ns / 1ps
`default_nettype none
package wfs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int HALF_W   = 5;
  localparam int SEEN_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;
  localparam logic [HALF_W-1:0] HALF_RESET = 5'd31;
  localparam logic [SAMPLE_W-1:0] PAD_RESET = 16'd8192;
  localparam logic [4:0] DIV_STEPS = 5'd16;

  // function codes of an input beat
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE   = 1'd1;

  typedef struct packed {
    logic [1:0]          func;
    logic [5:0]          coef_index;
    logic [COEF_W-1:0]   coef_value;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE_CHK,
    ST_FLUSH_SKIP,
    ST_FLUSH_NEXT,
    ST_MAC_ISSUE,
    ST_MAC_DRAIN,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic wr_weight;
    logic take_sample;
    logic flush_init;
    logic shift_skip;
    logic shift_emit;
    logic close;
    logic mac_start;
    logic mac_step;
    logic div_start;
    logic div_step;
    logic load_out;
    logic out_pass;
    logic out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic stream_open;
    logic h_zero;
    logic win_full;
    logic skip_zero;
    logic emit_zero;
    logic issue_last;
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/wfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module wfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/wfs_ctrl.sv =====
// Sequencing state machine of the smoother
`timescale 1ns / 1ps
`default_nettype none
module wfs_ctrl
  import wfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_stall,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   flush_r, flush_nxt;
  logic   pass_r, pass_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flush_r <= 1'b0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_LOAD: begin
              cmd.wr_weight = 1'b1;
            end
            FUNC_SAMPLE: begin
              cmd.take_sample = 1'b1;
              state_nxt = ST_SAMPLE_CHK;
            end
            FUNC_FLUSH: begin
              if (sts.stream_open) begin
                cmd.flush_init = 1'b1;
                flush_nxt = 1'b1;
                state_nxt = ST_FLUSH_SKIP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SAMPLE_CHK: begin
        flush_nxt = 1'b0;
        if (sts.h_zero) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else if (sts.win_full) begin
          pass_nxt      = 1'b0;
          cmd.mac_start = 1'b1;
          state_nxt     = ST_MAC_ISSUE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH_SKIP: begin
        if (sts.skip_zero) begin
          state_nxt = ST_FLUSH_NEXT;
        end else begin
          cmd.shift_skip = 1'b1;
        end
      end
      ST_FLUSH_NEXT: begin
        if (sts.emit_zero) begin
          cmd.close = 1'b1;
          flush_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          cmd.shift_emit = 1'b1;
          cmd.mac_start  = 1'b1;
          pass_nxt       = 1'b0;
          state_nxt      = ST_MAC_ISSUE;
        end
      end
      ST_MAC_ISSUE: begin
        cmd.mac_step = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_MAC_DRAIN;
        end
      end
      ST_MAC_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_pass = pass_r;
          cmd.out_last = flush_r && sts.emit_zero;
          state_nxt    = flush_r ? ST_FLUSH_NEXT : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // at most one operation touches the delay line or weights per cycle
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_weight, cmd.take_sample, cmd.shift_skip, cmd.shift_emit,
              cmd.mac_step}))
    else $error("overlapping datapath operations");
  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending beat");
  // flush states are only reached with an open stream
  a_flush_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH_SKIP || state_r == ST_FLUSH_NEXT) |-> sts.stream_open)
    else $error("flush without open stream");
`endif

endmodule
`default_nettype wire

// ===== src/wfs_dp.sv =====
// Datapath: delay line, weights, multiply-accumulate, serial divider, output register
`timescale 1ns / 1ps
`default_nettype none
module wfs_dp
  import wfs_pkg::*;
#(
  parameter int TAPS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 sts,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  localparam int AW    = $clog2(TAPS);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int HMAX  = (TAPS - 1) / 2;
  localparam int ACC_W = 2 * SAMPLE_W + AW;
  localparam int TOT_W = COEF_W + AW;

  logic [HALF_W-1:0]   half_length_r;
  logic [SAMPLE_W-1:0] pad_value_r;
  logic [SAMPLE_W-1:0] pad_stream_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]       ptr_r;
  logic [FW-1:0]       fill_r;
  logic [SEEN_W-1:0]   seen_r;
  logic                open_r;
  logic [HALF_W-1:0]   skip_r;
  logic [HALF_W-1:0]   emit_r;
  logic [TAPS-1:0]     wv_r;
  logic [AW-1:0]       j_r;
  logic [AW-1:0]       d_r;
  logic                s1_v_r;
  logic                s2_v_r;
  logic                wv_q_r;
  logic                inwin_q_r;
  logic [2*SAMPLE_W-1:0] prod_r;
  logic [COEF_W-1:0]   wsel_r;
  logic [ACC_W-1:0]    acc_r;
  logic [TOT_W-1:0]    tot_r;
  logic [ACC_W-1:0]    rem_r;
  logic [ACC_W-1:0]    div_r;
  logic [SAMPLE_W-1:0] quo_r;
  logic                sat_r;
  logic                zero_r;
  logic [4:0]          dcnt_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [HALF_W-1:0]   h_act;
  logic [AW-1:0]       twice_h;
  logic [AW-1:0]       ptr_inc;
  logic                shift_any;
  logic [AW:0]         raddr_sum;
  logic [AW-1:0]       draddr;
  logic                idx_ok;
  logic                dram_we;
  logic [SAMPLE_W-1:0] dram_wdata;
  logic [SAMPLE_W-1:0] dram_q;
  logic [COEF_W-1:0]   wram_q;
  logic [COEF_W-1:0]   w_eff;
  logic [SAMPLE_W-1:0] x_eff;
  logic [HALF_W-1:0]   n_pend;
  logic                div_ge;
  logic [SAMPLE_W-1:0] result;

  // active half window, limited by the tap count
  assign h_act   = (32'(half_length_r) > HMAX) ? HALF_W'(HMAX) : half_length_r;
  assign twice_h = AW'({h_act, 1'b0});

  // circular delay line addressing
  assign ptr_inc   = (ptr_r == AW'(TAPS - 1)) ? '0 : ptr_r + 1'b1;
  assign shift_any = cmd.take_sample || cmd.shift_skip || cmd.shift_emit;
  assign raddr_sum = (AW+1)'(ptr_r) + (AW+1)'(TAPS) - (AW+1)'(d_r);
  assign draddr    = (raddr_sum >= (AW+1)'(TAPS)) ? AW'(raddr_sum - (AW+1)'(TAPS))
                                                 : AW'(raddr_sum);
  assign dram_we    = shift_any;
  assign dram_wdata = cmd.take_sample ? in_data.sample : pad_value_r;
  assign idx_ok     = (32'(in_data.coef_index) < TAPS);

  wfs_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (ptr_inc),
    .wdata (dram_wdata),
    .raddr (draddr),
    .rdata (dram_q)
  );

  wfs_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.wr_weight && idx_ok),
    .waddr (AW'(in_data.coef_index)),
    .wdata (in_data.coef_value),
    .raddr (j_r),
    .rdata (wram_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_length_r <= HALF_RESET;
      pad_value_r   <= PAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_LENGTH: half_length_r <= cfg_data[HALF_W-1:0];
        REG_PAD_VALUE:   pad_value_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight valid bits, unwritten weights read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else if (cmd.wr_weight && idx_ok) begin
      wv_r[AW'(in_data.coef_index)] <= 1'b1;
    end
  end

  // stream bookkeeping
  assign n_pend = (seen_r < SEEN_W'(h_act)) ? HALF_W'(seen_r) : h_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      seen_r <= '0;
      fill_r <= '0;
      ptr_r  <= '0;
    end else begin
      if (shift_any) begin
        ptr_r <= ptr_inc;
      end
      if (cmd.take_sample && !open_r) begin
        open_r <= 1'b1;
        seen_r <= SEEN_W'(1);
        fill_r <= FW'(1);
      end else begin
        if (cmd.take_sample && seen_r != SEEN_MAX) begin
          seen_r <= seen_r + 1'b1;
        end
        if (shift_any && fill_r != FW'(TAPS)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.close) begin
        open_r <= 1'b0;
        seen_r <= '0;
      end
    end
  end

  // stream pad, sample hold and flush counters
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      sample_r <= in_data.sample;
      if (!open_r) begin
        pad_stream_r <= pad_value_r;
      end
    end
    if (cmd.flush_init) begin
      skip_r <= h_act - n_pend;
      emit_r <= n_pend;
    end else begin
      if (cmd.shift_skip) begin
        skip_r <= skip_r - 1'b1;
      end
      if (cmd.shift_emit) begin
        emit_r <= emit_r - 1'b1;
      end
    end
  end

  // multiply-accumulate pipeline: read, multiply, accumulate
  assign w_eff = wv_q_r ? wram_q : '0;
  assign x_eff = inwin_q_r ? dram_q : pad_stream_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.mac_step;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      j_r <= '0;
      d_r <= twice_h;
    end else if (cmd.mac_step) begin
      j_r <= j_r + 1'b1;
      d_r <= d_r - 1'b1;
    end
    wv_q_r    <= wv_r[j_r];
    inwin_q_r <= (FW'(d_r) < fill_r);
    prod_r    <= w_eff * x_eff;
    wsel_r    <= w_eff;
    if (cmd.mac_start) begin
      acc_r <= '0;
      tot_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
      tot_r <= tot_r + TOT_W'(wsel_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_ge = (rem_r >= div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DIV_STEPS;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= acc_r;
      div_r  <= ACC_W'(tot_r) << (SAMPLE_W - 1);
      quo_r  <= '0;
      zero_r <= (tot_r == '0);
      sat_r  <= (acc_r >= {tot_r, {SAMPLE_W{1'b0}}});
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - div_r;
      end
      quo_r <= {quo_r[SAMPLE_W-2:0], div_ge};
      div_r <= div_r >> 1;
    end
  end

  assign result = zero_r ? '0 : (sat_r ? '1 : quo_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.smoothed <= cmd.out_pass ? sample_r : result;
      out_data_r.last     <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status towards the controller
  always_comb begin
    sts.stream_open = open_r;
    sts.h_zero      = (h_act == '0);
    sts.win_full    = (seen_r > SEEN_W'(h_act));
    sts.skip_zero   = (skip_r == '0);
    sts.emit_zero   = (emit_r == '0);
    sts.issue_last  = (j_r == twice_h);
    sts.pipe_busy   = s1_v_r || s2_v_r;
    sts.div_done    = (dcnt_r == '0);
    sts.out_free    = !out_valid_r || !out_stall;
  end

`ifndef NO_ASSERTIONS
  // the divider never steps past its last quotient bit
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> dcnt_r != '0)
    else $error("divider stepped when idle");
  // a closed stream holds no sample count
  a_closed_seen: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> seen_r == '0)
    else $error("sample count without open stream");
  // the delay line fill never passes its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= TAPS)
    else $error("delay line fill overflow");
`endif

endmodule
`default_nettype wire

// ===== src/windowed_fir_smoother_core.sv =====
// Top level of the windowed FIR smoother
//
// Input channel in_valid/in_stall/in_data: a beat is taken when in_valid is
// high and in_stall low. func selects a weight load, a sample or a flush.
// Result channel out_valid/out_stall/out_data: one smoothed value per
// sample, once the sample H positions later arrives or during the flush;
// last marks the final value of a flush.
// Configuration cfg_valid/cfg_ready/cfg_index/cfg_data: always ready; the
// user must write it only while the block is idle, which is not enforced.
// Steps: a weight load is written as it is accepted. A sample that yields
// a value passes accept, check, 2H+1 multiply-accumulate reads of the
// weight and delay line memories, a pipeline drain, the 16-step serial
// divide and load; one tap per cycle and the divide set the time.
// With H = 0 a sample passes accept, check and load only.
// A flush first shifts in pads ahead of the first pending value, then per
// value it returns shifts one more pad and runs the same steps.
// Reset (synchronous, rst_n low) clears weights to zero, closes the stream
// and restores H = 31 and pad 8192, unsigned 16-bit. A stalled result holds
// the output register; the block then waits before loading the next value.
`timescale 1ns / 1ps
`default_nettype none
module windowed_fir_smoother_core
  import wfs_pkg::*;
#(
  parameter int TAPS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  wfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  wfs_dp #(.TAPS(TAPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the windowed FIR smoother core
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import wfs_pkg::*;

  localparam int TAP_N = 63;
  localparam int HALF_MAX = (TAP_N - 1) / 2;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  windowed_fir_smoother_core #(.TAPS(TAP_N)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [SAMPLE_W-1:0] win_line [TAP_N];
  logic [COEF_W-1:0] tap_weight [TAP_N];
  int unsigned seen_n;
  bit stream_on;
  logic [HALF_W-1:0] half_reg;
  logic [SAMPLE_W-1:0] pad_reg;

  out_item_t smooth_q[$];
  int errors = 0;
  int mismatches = 0;
  int dir_errors;
  int cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;

  // directed rows: item plus optional typed expectation
  typedef struct {
    in_item_t item;
    bit has_exp;
    logic [SAMPLE_W-1:0] exp_val;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned eff_half();
    return (half_reg > HALF_MAX) ? HALF_MAX : int'(half_reg);
  endfunction

  function automatic void push_win(logic [SAMPLE_W-1:0] v);
    for (int i = TAP_N - 1; i > 0; i--) win_line[i] = win_line[i - 1];
    win_line[0] = v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] window_avg(int unsigned h);
    longint unsigned wsum;
    longint unsigned acc;
    longint unsigned q;
    wsum = 0;
    acc = 0;
    for (int unsigned j = 0; j <= 2 * h; j++) begin
      wsum += tap_weight[j];
      acc += longint'(tap_weight[j]) * win_line[2 * h - j];
    end
    if (wsum == 0) return '0;
    q = acc / wsum;
    if (q > 65535) q = 65535;
    return q[SAMPLE_W-1:0];
  endfunction

  // work out results of one accepted beat
  function automatic void predict_beat(in_item_t it);
    int unsigned h;
    int unsigned n;
    out_item_t r;
    h = eff_half();
    case (it.func)
      FUNC_LOAD: begin
        if (it.coef_index < TAP_N) tap_weight[it.coef_index] = it.coef_value;
      end
      FUNC_SAMPLE: begin
        if (!stream_on) begin
          for (int i = 0; i < TAP_N; i++) win_line[i] = pad_reg;
          stream_on = 1'b1;
          seen_n = 0;
        end
        push_win(it.sample);
        if (seen_n < 63) seen_n++;
        if (h == 0) begin
          r.smoothed = it.sample;
          r.last = 1'b0;
          smooth_q = {smooth_q, r};
        end else if (seen_n > h) begin
          r.smoothed = window_avg(h);
          r.last = 1'b0;
          smooth_q = {smooth_q, r};
        end
      end
      FUNC_FLUSH: begin
        if (stream_on) begin
          n = (seen_n < h) ? seen_n : h;
          for (int unsigned k = 0; k < h; k++) begin
            push_win(pad_reg);
            if (k >= h - n) begin
              r.smoothed = window_avg(h);
              r.last = (k == h - 1);
              smooth_q = {smooth_q, r};
            end
          end
          stream_on = 1'b0;
          seen_n = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (smooth_q.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result %h last %b", out_data.smoothed, out_data.last);
        mismatches++;
      end else begin
        out_item_t e;
        e = smooth_q.pop_front();
        if (e.smoothed !== out_data.smoothed || e.last !== out_data.last) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected %h/%b got %h/%b", e.smoothed, e.last,
                     out_data.smoothed, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // drive one beat from a falling edge; stall is stable until the next rise
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    while (in_stall) @(negedge clk);
    predict_beat(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait for all results, then let the block settle
  task automatic drain_all();
    in_valid = 1'b0;
    while (smooth_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // register write, only once the block is idle with no result pending
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    while (in_stall || smooth_q.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    while (!cfg_ready) @(negedge clk);
    if (idx == REG_HALF_LENGTH) half_reg = val[HALF_W-1:0];
    else pad_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t mk(logic [1:0] f, logic [5:0] ci, logic [15:0] cv,
                                  logic [15:0] s);
    in_item_t it;
    it.func = f;
    it.coef_index = ci;
    it.coef_value = cv;
    it.sample = s;
    return it;
  endfunction

  function automatic in_item_t rand_sample();
    return mk(FUNC_SAMPLE, 6'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  task automatic load_weights(int unsigned h, bit rect);
    for (int unsigned j = 0; j <= 2 * h; j++)
      send_beat(mk(FUNC_LOAD, 6'(j), rect ? 16'd1 : 16'($urandom_range(32768)),
                   16'($urandom)));
  endtask

  // one random stream of well-formed or broken shape
  task automatic random_stream(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(19))
        0: send_beat(mk(FUNC_LOAD, 6'($urandom), 16'($urandom), 16'($urandom)));
        1: send_beat(mk(2'd3, 6'($urandom), 16'($urandom), 16'($urandom)));
        default: send_beat(rand_sample());
      endcase
    end
    send_beat(mk(FUNC_FLUSH, 6'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  dir_row_t dir_rows[$];

  initial begin
    int pct_send [4] = '{0, 80, 0, 15};
    int pct_recv [4] = '{0, 0, 80, 15};
    int unsigned h;
    dir_errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < TAP_N; i++) begin
      win_line[i] = '0;
      tap_weight[i] = '0;
    end
    seen_n = 0;
    stream_on = 1'b0;
    half_reg = HALF_RESET;
    pad_reg = PAD_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero weights after reset, flush with no stream, unused func
    dir_rows = {dir_rows, dir_row_t'{mk(FUNC_FLUSH, '0, '0, '0), 1'b0, '0}};
    dir_rows = {dir_rows, dir_row_t'{mk(2'd3, 6'h3f, 16'hffff, 16'hffff), 1'b0, '0}};
    for (int i = 0; i < 32; i++)
      dir_rows = {dir_rows,
                  dir_row_t'{mk(FUNC_SAMPLE, '0, '0, 16'hffff), (i == 31), 16'd0}};
    dir_rows = {dir_rows, dir_row_t'{mk(FUNC_FLUSH, '0, '0, '0), 1'b0, '0}};
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].item);
      if (dir_rows[i].has_exp && (smooth_q.size() == 0 ||
          smooth_q[$].smoothed !== dir_rows[i].exp_val)) begin
        dir_errors++;
        $display("directed row %0d: typed expectation not met", i);
      end
    end
    drain_all();

    // pass-through with H zero, extreme samples, weights ignored
    write_reg(REG_HALF_LENGTH, 16'd0);
    write_reg(REG_PAD_VALUE, 16'hffff);
    send_beat(mk(FUNC_SAMPLE, '0, '0, 16'h0000));
    send_beat(mk(FUNC_SAMPLE, '0, '0, 16'hffff));
    send_beat(mk(FUNC_FLUSH, '0, '0, '0));
    drain_all();

    // H 1: max weights, bad tap index, short stream flush
    write_reg(REG_HALF_LENGTH, 16'd1);
    write_reg(REG_PAD_VALUE, 16'h0000);
    send_beat(mk(FUNC_LOAD, 6'd0, 16'd32768, '0));
    send_beat(mk(FUNC_LOAD, 6'd1, 16'hffff, '0));
    send_beat(mk(FUNC_LOAD, 6'd2, 16'd1, '0));
    send_beat(mk(FUNC_LOAD, 6'd63, 16'hffff, '0));
    send_beat(mk(FUNC_SAMPLE, '0, '0, 16'hffff));
    send_beat(mk(FUNC_FLUSH, '0, '0, '0));
    send_beat(mk(FUNC_SAMPLE, '0, '0, 16'h1234));
    send_beat(mk(FUNC_SAMPLE, '0, '0, 16'hffff));
    // change H mid-stream
    write_reg(REG_HALF_LENGTH, 16'd3);
    send_beat(mk(FUNC_SAMPLE, '0, '0, 16'h0001));
    send_beat(mk(FUNC_FLUSH, '0, '0, '0));
    drain_all();

    // random phases over idling patterns and settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_send[ph % 4];
      recv_stall_pct = pct_recv[ph % 4];
      case (ph)
        0: h = 0;
        1: h = 31;
        default: h = $urandom_range(1, 4);
      endcase
      write_reg(REG_HALF_LENGTH, 16'(h));
      write_reg(REG_PAD_VALUE, (ph == 3) ? 16'h0000 : 16'($urandom));
      load_weights(h, (ph == 3));
      random_stream((h == 31) ? 8 : $urandom_range(2, 10));
      if (ph == 2) begin
        // sender holds off until every result is back
        while (smooth_q.size() != 0) @(negedge clk);
        random_stream($urandom_range(3, 10));
      end
      drain_all();
    end

    if (errors == 0 && dir_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
